@@ sv/ttip_pkg.sv @@
`default_nettype none

package ttip_pkg;

    localparam int OFFSET_WIDTH_DEF = 16;
    localparam int VALUE_WIDTH_DEF  = 64;

    localparam int CH_W     = 8;
    localparam int BASE_W   = 6;
    localparam int VALUE_W  = 64;
    localparam int END_W    = 16;

    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CH_A_UP  = 8'h41;
    localparam logic [CH_W-1:0] CH_Z_UP  = 8'h5A;
    localparam logic [CH_W-1:0] CH_X_UP  = 8'h58;
    localparam logic [CH_W-1:0] CH_A_LO  = 8'h61;
    localparam logic [CH_W-1:0] CH_Z_LO  = 8'h7A;
    localparam logic [CH_W-1:0] CH_X_LO  = 8'h78;

    localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_W-1:0] BASE_ONE  = 6'd1;
    localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;
    localparam logic [BASE_W-1:0] BASE_MAX  = 6'd36;
    localparam logic [BASE_W-1:0] NO_DIGIT  = 6'd63;
    localparam logic [BASE_W-1:0] LETTER_OFS = 6'd10;

    typedef enum logic [2:0] {
        PH_DONE,
        PH_WS,
        PH_SIGN,
        PH_ZERO,
        PH_ZX,
        PH_DIG
    } t_phase;

    typedef struct packed {
        logic [CH_W-1:0]   ch;
        logic              first;
        logic [BASE_W-1:0] base_sel;
    } t_in;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [END_W-1:0]          end_offset;
        logic                      no_digits;
        logic                      overflow;
    } t_out;

    function automatic logic is_space(input logic [CH_W-1:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic [BASE_W-1:0] digit_of(input logic [CH_W-1:0] c);
        logic [BASE_W-1:0] d;
        d = NO_DIGIT;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = BASE_W'(c - CH_ZERO);
        end else if (c >= CH_A_LO && c <= CH_Z_LO) begin
            d = BASE_W'(c - CH_A_LO) + LETTER_OFS;
        end else if (c >= CH_A_UP && c <= CH_Z_UP) begin
            d = BASE_W'(c - CH_A_UP) + LETTER_OFS;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

@@ sv/text_to_integer_parser_unit.sv @@
// Path: input reg, then result reg; each byte's digit step is one multiply-add by the base.
// Throughput: one byte per cycle while the result reg is free or being taken by i_out_ready.
// A byte that ends a number yields one result; all other bytes yield none.
// Reset: synchronous, active low; clears both stage valids and the parse phase.
// After reset bytes are ignored until a first-byte marker arrives.
`default_nettype none

module text_to_integer_parser_unit #(
    parameter int OFFSET_WIDTH = ttip_pkg::OFFSET_WIDTH_DEF,
    parameter int VALUE_WIDTH  = ttip_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire ttip_pkg::t_in i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output ttip_pkg::t_out     o_out_data
);
    import ttip_pkg::*;

    localparam int PROD_W = VALUE_WIDTH + 7;
    localparam logic [OFFSET_WIDTH-1:0] OFF_MAX = '1;

    logic                    r_in_valid;
    t_in                     r_in;
    logic                    r_out_valid;
    t_out                    r_out;

    t_phase                  r_phase, n_phase;
    logic [VALUE_WIDTH-1:0]  r_acc, n_acc;
    logic [BASE_W-1:0]       r_base, n_base;
    logic                    r_neg, n_neg;
    logic [OFFSET_WIDTH-1:0] r_off, n_off;
    logic                    r_seen, n_seen;
    logic                    r_ovf, n_ovf;

    t_phase                  e_phase;
    logic [VALUE_WIDTH-1:0]  e_acc;
    logic [BASE_W-1:0]       e_base;
    logic                    e_neg;
    logic [OFFSET_WIDTH-1:0] e_off;
    logic                    e_seen;
    logic                    e_ovf;

    logic                    adv;
    logic                    fire;
    logic                    bad_base;
    logic                    lead;
    logic                    try_en;
    logic                    res;
    logic [BASE_W-1:0]       base_t;
    logic [VALUE_WIDTH-1:0]  acc_t;
    logic [BASE_W-1:0]       dig;
    logic [PROD_W-1:0]       prod;
    logic [PROD_W-1:0]       limit;
    logic [OFFSET_WIDTH-1:0] end_pos;
    logic [VALUE_WIDTH-1:0]  mag;
    t_out                    res_data;

    assign adv         = !r_out_valid || i_out_ready;
    assign fire        = r_in_valid && adv;
    assign o_in_ready  = !r_in_valid || adv;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    // a first byte restarts the parse with cleared state and the base taken from base_sel
    always_comb begin
        if (r_in.first) begin
            e_phase = PH_WS;
            e_acc   = '0;
            e_base  = r_in.base_sel;
            e_neg   = 1'b0;
            e_off   = '0;
            e_seen  = 1'b0;
            e_ovf   = 1'b0;
        end else begin
            e_phase = r_phase;
            e_acc   = r_acc;
            e_base  = r_base;
            e_neg   = r_neg;
            e_off   = r_off;
            e_seen  = r_seen;
            e_ovf   = r_ovf;
        end
    end

    assign bad_base = r_in.first && (r_in.base_sel == BASE_ONE || r_in.base_sel > BASE_MAX);
    assign dig      = digit_of(r_in.ch);
    assign prod     = PROD_W'(acc_t) * PROD_W'(base_t) + PROD_W'(dig);
    assign limit    = {8'd0, {(VALUE_WIDTH-1){1'b1}}} + PROD_W'(e_neg);

    always_comb begin
        n_phase = e_phase;
        n_acc   = e_acc;
        n_base  = e_base;
        n_neg   = e_neg;
        n_off   = e_off;
        n_seen  = e_seen;
        n_ovf   = e_ovf;
        lead    = 1'b0;
        try_en  = 1'b0;
        res     = 1'b0;
        base_t  = e_base;
        acc_t   = e_acc;
        end_pos = e_off;

        if (bad_base) begin
            res = 1'b1;
        end else begin
            unique case (e_phase)
                PH_DONE: begin
                end
                PH_WS: begin
                    if (is_space(r_in.ch)) begin
                    end else if (r_in.ch == CH_PLUS || r_in.ch == CH_MINUS) begin
                        n_neg   = (r_in.ch == CH_MINUS);
                        n_phase = PH_SIGN;
                    end else begin
                        lead = 1'b1;
                    end
                end
                PH_SIGN: begin
                    lead = 1'b1;
                end
                PH_ZERO: begin
                    if (r_in.ch == CH_X_LO || r_in.ch == CH_X_UP) begin
                        n_phase = PH_ZX;
                    end else begin
                        base_t = (e_base == BASE_AUTO) ? BASE_OCT : e_base;
                        try_en = 1'b1;
                    end
                end
                PH_ZX: begin
                    if (dig < BASE_HEX) begin
                        base_t = BASE_HEX;
                        acc_t  = '0;
                        try_en = 1'b1;
                    end else begin
                        // back off to just after the zero
                        res     = 1'b1;
                        end_pos = (e_off != '0) ? e_off - 1'b1 : '0;
                    end
                end
                PH_DIG: begin
                    try_en = 1'b1;
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase
        end

        if (lead) begin
            if (r_in.ch == CH_ZERO && (e_base == BASE_AUTO || e_base == BASE_HEX)) begin
                n_acc   = '0;
                n_seen  = 1'b1;
                n_phase = PH_ZERO;
            end else begin
                base_t = (e_base == BASE_AUTO) ? BASE_DEC : e_base;
                try_en = 1'b1;
            end
        end

        if (try_en) begin
            n_base = base_t;
            if (dig < base_t) begin
                n_acc   = prod[VALUE_WIDTH-1:0];
                n_ovf   = e_ovf || (prod > limit);
                n_seen  = 1'b1;
                n_phase = PH_DIG;
            end else begin
                res = 1'b1;
            end
        end

        if (res) begin
            n_phase = PH_DONE;
        end else if (e_phase != PH_DONE && e_off != OFF_MAX) begin
            n_off = e_off + 1'b1;
        end
    end

    assign mag = e_neg ? (~e_acc + 1'b1) : e_acc;

    always_comb begin
        res_data.value      = e_seen ? VALUE_W'($signed(mag)) : '0;
        res_data.end_offset = e_seen ? END_W'(end_pos) : '0;
        res_data.no_digits  = !e_seen;
        res_data.overflow   = e_seen && e_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DONE;
        end else if (fire) begin
            r_phase <= n_phase;
        end
        if (fire) begin
            r_acc  <= n_acc;
            r_base <= n_base;
            r_neg  <= n_neg;
            r_off  <= n_off;
            r_seen <= n_seen;
            r_ovf  <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && res) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (fire && res) begin
            r_out <= res_data;
        end
    end

`ifndef SYNTHESIS
    a_no_digits_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.no_digits) |->
            (r_out.value == '0 && r_out.end_offset == '0 && !r_out.overflow))
        else $error("no-digits result carries nonzero fields");

    a_done_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && res) |=> (r_phase == PH_DONE))
        else $error("parse not closed after result");

    a_digit_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DIG || r_phase == PH_ZERO) |-> r_seen)
        else $error("digit phase without a digit");

    a_prefix_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ZX) |-> (r_seen && r_acc == '0))
        else $error("hex prefix with nonzero accumulator");

    a_base_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_DONE) |-> (r_base <= BASE_MAX && r_base != BASE_ONE))
        else $error("active parse with illegal base");
`endif

endmodule

`default_nettype wire
